/* hw/rtl/active_address_table_with_aging_unit_assert.svh */
// Assertion macros for the active address table.
`ifndef ACTIVE_ADDRESS_TABLE_WITH_AGING_UNIT_ASSERT_SVH
`define ACTIVE_ADDRESS_TABLE_WITH_AGING_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define AAT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("aat assertion failed");
`define AAT_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("aat assertion failed");
`else
`define AAT_ASSERT_IMP(label, clk, rst, ante, cons)
`define AAT_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

/* hw/rtl/aat_pkg.sv */
// Shared constants, types and codes of the active address table.
package aat_pkg;

   localparam int TABLE_ENTRIES = 10;
   localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
   localparam int LIST_CAP      = 10;
   localparam int LIST_LIMIT    = (TABLE_ENTRIES < LIST_CAP) ? TABLE_ENTRIES : LIST_CAP;
   localparam int ADDR_W        = 32;
   localparam int TIME_W        = 32;
   localparam int KIND_W        = 2;
   localparam int SLOT_W        = 4;
   localparam int COUNT_W       = 4;
   localparam int MAXC_W        = 4;

   localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd30000;

   localparam logic [KIND_W-1:0] KIND_ACK  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ADDR = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SUM  = 2'd2;

   localparam logic REQ_TRACK = 1'b0;
   localparam logic REQ_LIST  = 1'b1;

   typedef enum logic [1:0] {
      CMP_EQ,
      CMP_LT,
      CMP_AGE
   } cmp_op_type;

   typedef struct packed {
      cmp_op_type        op;
      logic [TIME_W-1:0] a;
      logic [TIME_W-1:0] b;
      logic [TIME_W-1:0] c;
   } cmp_req_type;

   typedef struct packed {
      logic              wr_entry;
      logic              wr_stamp;
      logic              clr;
      logic [IDX_W-1:0]  idx;
      logic [ADDR_W-1:0] addr;
      logic [TIME_W-1:0] stamp;
   } tbl_wr_type;

endpackage

/* hw/rtl/aat_cmp_unit.sv */
// Shared compare unit: address match, stamp order and modular age check.
module aat_cmp_unit import aat_pkg::*; (
   input  cmp_req_type cmp,
   output logic        hit
);

   logic [TIME_W-1:0] diff;

   assign diff = cmp.a - cmp.b;

   always_comb begin
      case (cmp.op)
         CMP_EQ:  hit = (cmp.a == cmp.b);
         CMP_LT:  hit = (cmp.a < cmp.b);
         CMP_AGE: hit = (diff > cmp.c);
         default: hit = 1'b0;
      endcase
   end

endmodule

/* hw/rtl/aat_table.sv */
// Entry storage: addresses, time stamps and valid bits.
module aat_table import aat_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  tbl_wr_type        wr,
   input  logic [IDX_W-1:0]  rd_idx,
   output logic [ADDR_W-1:0] rd_addr,
   output logic [TIME_W-1:0] rd_stamp,
   output logic              rd_valid
);

   logic [ADDR_W-1:0] addr_ff  [TABLE_ENTRIES];
   logic [TIME_W-1:0] stamp_ff [TABLE_ENTRIES];
   logic              valid_ff [TABLE_ENTRIES];

   always_ff @(posedge clock) begin
      if (wr.wr_entry) begin
         addr_ff[wr.idx] <= wr.addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            stamp_ff[i] <= '0;
            valid_ff[i] <= 1'b0;
         end
      end else begin
         if (wr.wr_entry || wr.wr_stamp) begin
            stamp_ff[wr.idx] <= wr.stamp;
         end
         if (wr.wr_entry) begin
            valid_ff[wr.idx] <= 1'b1;
         end else if (wr.clr) begin
            valid_ff[wr.idx] <= 1'b0;
         end
      end
   end

   assign rd_addr  = addr_ff[rd_idx];
   assign rd_stamp = stamp_ff[rd_idx];
   assign rd_valid = valid_ff[rd_idx];

endmodule

/* hw/rtl/active_address_table_with_aging_unit.sv */
// Active address table with aging: a small sequencer walks the table one slot
// per cycle through a single shared compare unit, but waits on a slot whose
// item finds the result register full. A track request goes through accept,
// match scan, victim scan and write, and ends at the match scan when the address
// is already present; a list request goes through accept, slot scan, stop check
// and summary. The request side is ready only between requests; one result
// register lets the next request start while the last item still waits.
module active_address_table_with_aging_unit import aat_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_type,
   input  logic [ADDR_W-1:0]   req_ip_addr,
   input  logic [TIME_W-1:0]   req_now_ms,
   input  logic [MAXC_W-1:0]   req_max_count,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [KIND_W-1:0]   rsp_item_kind,
   output logic [ADDR_W-1:0]   rsp_out_ip,
   output logic [SLOT_W-1:0]   rsp_slot_index,
   output logic                rsp_was_hit,
   output logic                rsp_evicted,
   output logic [COUNT_W-1:0]  rsp_live_count,
   output logic                rsp_last,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [TIME_W-1:0]   csr_timeout_ms
);

`include "active_address_table_with_aging_unit_assert.svh"

   typedef enum logic [2:0] {
      S_IDLE,
      S_HIT,
      S_VICT,
      S_WRITE,
      S_LIST,
      S_SUM
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   limit_ff, limit_in;
   logic [ADDR_W-1:0]  ip_ff, ip_in;
   logic [TIME_W-1:0]  now_ff, now_in;
   logic [TIME_W-1:0]  oldest_ff, oldest_in;
   logic [IDX_W-1:0]   victim_ff, victim_in;
   logic [IDX_W-1:0]   slot_ff, slot_in;
   logic               ev_ff, ev_in;
   logic [TIME_W-1:0]  timeout_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]  kind_ff, kind_in;
   logic [ADDR_W-1:0]  oip_ff, oip_in;
   logic [SLOT_W-1:0]  oslot_ff, oslot_in;
   logic               hit_ff, hit_in;
   logic               oev_ff, oev_in;
   logic [COUNT_W-1:0] ocnt_ff, ocnt_in;
   logic               last_ff, last_in;

   logic               out_free;
   logic               emit_ack;
   logic               idx_last;
   logic [IDX_W-1:0]   rd_idx;
   logic [ADDR_W-1:0]  rd_addr;
   logic [TIME_W-1:0]  rd_stamp;
   logic               rd_valid;
   logic               cmp_hit;
   cmp_req_type        cmp;
   tbl_wr_type         tbl_wr;

   aat_table u_table (
      .clock    (clock),
      .reset    (reset),
      .wr       (tbl_wr),
      .rd_idx   (rd_idx),
      .rd_addr  (rd_addr),
      .rd_stamp (rd_stamp),
      .rd_valid (rd_valid)
   );

   aat_cmp_unit u_cmp (
      .cmp (cmp),
      .hit (cmp_hit)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign idx_last  = (idx_ff == CNT_W'(TABLE_ENTRIES - 1));
   assign rd_idx    = (idx_ff < CNT_W'(TABLE_ENTRIES)) ? idx_ff[IDX_W-1:0] : '0;

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      count_in  = count_ff;
      limit_in  = limit_ff;
      ip_in     = ip_ff;
      now_in    = now_ff;
      oldest_in = oldest_ff;
      victim_in = victim_ff;
      slot_in   = slot_ff;
      ev_in     = ev_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      kind_in      = kind_ff;
      oip_in       = oip_ff;
      oslot_in     = oslot_ff;
      hit_in       = hit_ff;
      oev_in       = oev_ff;
      ocnt_in      = ocnt_ff;
      last_in      = last_ff;
      emit_ack     = 1'b0;

      tbl_wr          = '0;
      tbl_wr.idx      = rd_idx;
      tbl_wr.addr     = ip_ff;
      tbl_wr.stamp    = now_ff;

      cmp.op = CMP_EQ;
      cmp.a  = rd_addr;
      cmp.b  = ip_ff;
      cmp.c  = timeout_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ip_in     = req_ip_addr;
               now_in    = req_now_ms;
               oldest_in = req_now_ms;
               victim_in = '0;
               idx_in    = '0;
               count_in  = '0;
               if (32'(req_max_count) >= 32'(LIST_LIMIT)) begin
                  limit_in = CNT_W'(LIST_LIMIT);
               end else begin
                  limit_in = CNT_W'(req_max_count);
               end
               state_in = (req_type == REQ_TRACK) ? S_HIT : S_LIST;
            end
         end
         S_HIT: begin
            if (rd_valid && cmp_hit) begin
               if (out_free) begin
                  tbl_wr.wr_stamp = 1'b1;
                  emit_ack        = 1'b1;
                  rsp_valid_in    = 1'b1;
                  kind_in         = KIND_ACK;
                  oip_in          = '0;
                  oslot_in        = SLOT_W'(rd_idx);
                  hit_in          = 1'b1;
                  oev_in          = 1'b0;
                  ocnt_in         = '0;
                  last_in         = 1'b1;
                  state_in        = S_IDLE;
               end
            end else if (idx_last) begin
               idx_in   = '0;
               state_in = S_VICT;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_VICT: begin
            cmp.op = CMP_LT;
            cmp.a  = rd_stamp;
            cmp.b  = oldest_ff;
            if (!rd_valid) begin
               slot_in  = rd_idx;
               ev_in    = 1'b0;
               state_in = S_WRITE;
            end else begin
               if (cmp_hit) begin
                  oldest_in = rd_stamp;
                  victim_in = rd_idx;
               end
               if (idx_last) begin
                  slot_in  = cmp_hit ? rd_idx : victim_ff;
                  ev_in    = 1'b1;
                  state_in = S_WRITE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         S_WRITE: begin
            tbl_wr.idx = slot_ff;
            if (out_free) begin
               tbl_wr.wr_entry = 1'b1;
               emit_ack        = 1'b1;
               rsp_valid_in    = 1'b1;
               kind_in         = KIND_ACK;
               oip_in          = '0;
               oslot_in        = SLOT_W'(slot_ff);
               hit_in          = 1'b0;
               oev_in          = ev_ff;
               ocnt_in         = '0;
               last_in         = 1'b1;
               state_in        = S_IDLE;
            end
         end
         S_LIST: begin
            cmp.op = CMP_AGE;
            cmp.a  = now_ff;
            cmp.b  = rd_stamp;
            if ((idx_ff == CNT_W'(TABLE_ENTRIES)) || (count_ff == limit_ff)) begin
               state_in = S_SUM;
            end else if (!rd_valid) begin
               idx_in = idx_ff + 1'b1;
            end else if (cmp_hit) begin
               tbl_wr.clr = 1'b1;
               idx_in     = idx_ff + 1'b1;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               kind_in      = KIND_ADDR;
               oip_in       = rd_addr;
               oslot_in     = SLOT_W'(rd_idx);
               hit_in       = 1'b0;
               oev_in       = 1'b0;
               ocnt_in      = '0;
               last_in      = 1'b0;
               count_in     = count_ff + 1'b1;
               idx_in       = idx_ff + 1'b1;
            end
         end
         S_SUM: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               kind_in      = KIND_SUM;
               oip_in       = '0;
               oslot_in     = '0;
               hit_in       = 1'b0;
               oev_in       = 1'b0;
               ocnt_in      = COUNT_W'(count_ff);
               last_in      = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         timeout_ff   <= TIMEOUT_RESET;
         idx_ff       <= '0;
         count_ff     <= '0;
         limit_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
         count_ff     <= count_in;
         limit_ff     <= limit_in;
         if (csr_valid) begin
            timeout_ff <= csr_timeout_ms;
         end
      end
      ip_ff     <= ip_in;
      now_ff    <= now_in;
      oldest_ff <= oldest_in;
      victim_ff <= victim_in;
      slot_ff   <= slot_in;
      ev_ff     <= ev_in;
      kind_ff   <= kind_in;
      oip_ff    <= oip_in;
      oslot_ff  <= oslot_in;
      hit_ff    <= hit_in;
      oev_ff    <= oev_in;
      ocnt_ff   <= ocnt_in;
      last_ff   <= last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_item_kind  = kind_ff;
   assign rsp_out_ip     = oip_ff;
   assign rsp_slot_index = oslot_ff;
   assign rsp_was_hit    = hit_ff;
   assign rsp_evicted    = oev_ff;
   assign rsp_live_count = ocnt_ff;
   assign rsp_last       = last_ff;

   `AAT_ASSERT_NXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)
   `AAT_ASSERT_IMP(a_ack_updates, clock, reset, emit_ack, tbl_wr.wr_entry || tbl_wr.wr_stamp)
   `AAT_ASSERT_IMP(a_count_le_limit, clock, reset, state_ff == S_LIST, count_ff <= limit_ff)

endmodule

/* bench/tb_active_address_table_with_aging_unit.sv */
// Self-checking testbench for the active address table with aging unit.
`timescale 1ns / 100ps

module tb_active_address_table_with_aging_unit import aat_pkg::*; ();

   localparam int STALL_LIMIT = 2000;
   localparam int POOL_SIZE   = 14;
   localparam int END_SETTLE  = 2 * TABLE_ENTRIES + 4;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [ADDR_W-1:0]  ip;
      logic [SLOT_W-1:0]  slot;
      logic               hit;
      logic               evicted;
      logic [COUNT_W-1:0] count;
      logic               last;
   } table_rsp_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic                req_type;
   logic [ADDR_W-1:0]   req_ip_addr;
   logic [TIME_W-1:0]   req_now_ms;
   logic [MAXC_W-1:0]   req_max_count;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [KIND_W-1:0]   rsp_item_kind;
   logic [ADDR_W-1:0]   rsp_out_ip;
   logic [SLOT_W-1:0]   rsp_slot_index;
   logic                rsp_was_hit;
   logic                rsp_evicted;
   logic [COUNT_W-1:0]  rsp_live_count;
   logic                rsp_last;
   logic                csr_valid;
   logic                csr_ready;
   logic [TIME_W-1:0]   csr_timeout_ms;

   // shadow copy of the table
   logic [ADDR_W-1:0]   sh_addr  [TABLE_ENTRIES];
   logic [TIME_W-1:0]   sh_stamp [TABLE_ENTRIES];
   logic                sh_valid [TABLE_ENTRIES];
   logic [TIME_W-1:0]   sh_timeout;

   table_rsp_type       awaited_rsp_q[$];
   logic [ADDR_W-1:0]   addr_pool[POOL_SIZE];
   logic [TIME_W-1:0]   wall_ms;
   int                  mismatch_count = 0;
   int                  req_idle_pct   = 30;
   int                  rsp_stall_pct  = 30;
   int                  rsp_hold_req   = 0;
   int                  rsp_hold_left  = 0;

   active_address_table_with_aging_unit u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_ip_addr    (req_ip_addr),
      .req_now_ms     (req_now_ms),
      .req_max_count  (req_max_count),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_item_kind  (rsp_item_kind),
      .rsp_out_ip     (rsp_out_ip),
      .rsp_slot_index (rsp_slot_index),
      .rsp_was_hit    (rsp_was_hit),
      .rsp_evicted    (rsp_evicted),
      .rsp_live_count (rsp_live_count),
      .rsp_last       (rsp_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_timeout_ms (csr_timeout_ms)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic void shadow_table_step(input logic rtype, input logic [ADDR_W-1:0] ip,
                                             input logic [TIME_W-1:0] now,
                                             input logic [MAXC_W-1:0] maxc);
      table_rsp_type     r;
      int                hit_slot;
      int                empty_slot;
      int                victim;
      int                slot;
      int                limit;
      int                emitted;
      logic [TIME_W-1:0] oldest;
      logic [TIME_W-1:0] age;
      r = '0;
      if (rtype == REQ_TRACK) begin
         r.kind = KIND_ACK;
         r.last = 1'b1;
         hit_slot = -1;
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (hit_slot < 0 && sh_valid[i] && sh_addr[i] == ip) hit_slot = i;
         end
         if (hit_slot >= 0) begin
            sh_stamp[hit_slot] = now;
            r.slot = SLOT_W'(hit_slot);
            r.hit  = 1'b1;
         end else begin
            empty_slot = -1;
            victim = 0;
            oldest = now;
            for (int i = 0; i < TABLE_ENTRIES && empty_slot < 0; i++) begin
               if (!sh_valid[i]) begin
                  empty_slot = i;
               end else if (sh_stamp[i] < oldest) begin
                  oldest = sh_stamp[i];
                  victim = i;
               end
            end
            slot = (empty_slot >= 0) ? empty_slot : victim;
            r.slot    = SLOT_W'(slot);
            r.evicted = sh_valid[slot];
            sh_addr[slot]  = ip;
            sh_stamp[slot] = now;
            sh_valid[slot] = 1'b1;
         end
         awaited_rsp_q.push_back(r);
      end else begin
         limit = (int'(maxc) > LIST_LIMIT) ? LIST_LIMIT : int'(maxc);
         emitted = 0;
         for (int i = 0; i < TABLE_ENTRIES && emitted < limit; i++) begin
            age = now - sh_stamp[i];
            if (sh_valid[i]) begin
               if (age > sh_timeout) begin
                  sh_valid[i] = 1'b0;
               end else begin
                  r = '0;
                  r.kind = KIND_ADDR;
                  r.ip   = sh_addr[i];
                  r.slot = SLOT_W'(i);
                  awaited_rsp_q.push_back(r);
                  emitted++;
               end
            end
         end
         r = '0;
         r.kind  = KIND_SUM;
         r.count = COUNT_W'(emitted);
         r.last  = 1'b1;
         awaited_rsp_q.push_back(r);
      end
   endfunction

   task automatic offer_request(input logic rtype, input logic [ADDR_W-1:0] ip,
                                input logic [TIME_W-1:0] now, input logic [MAXC_W-1:0] maxc);
      int gap;
      req_type      <= rtype;
      req_ip_addr   <= ip;
      req_now_ms    <= now;
      req_max_count <= maxc;
      req_valid     <= 1'b1;
      do @(posedge clock); while (!req_ready);
      shadow_table_step(rtype, ip, now, maxc);
      if ($urandom_range(99) < req_idle_pct) begin
         gap = $urandom_range(1, 4);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic quiesce();
      req_valid <= 1'b0;
      while (awaited_rsp_q.size() != 0) @(posedge clock);
   endtask

   task automatic set_timeout(input logic [TIME_W-1:0] value);
      csr_timeout_ms <= value;
      csr_valid      <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      sh_timeout = value;
      csr_valid <= 1'b0;
   endtask

   task automatic random_traffic(input int n_items, input int step_max);
      int                k;
      int                pick;
      logic [TIME_W-1:0] now;
      logic [ADDR_W-1:0] ip;
      for (k = 0; k < n_items; k++) begin
         if ($urandom_range(19) == 0) begin
            now = $urandom;
         end else begin
            wall_ms += $urandom_range(0, step_max);
            now = wall_ms;
         end
         ip = addr_pool[$urandom_range(POOL_SIZE - 1)];
         pick = $urandom_range(99);
         if (pick < 62)
            offer_request(REQ_TRACK, ip, now, MAXC_W'($urandom_range(15)));
         else if (pick < 72)
            offer_request(REQ_TRACK, $urandom, now, MAXC_W'($urandom_range(15)));
         else
            offer_request(REQ_LIST, $urandom, now, MAXC_W'($urandom_range(15)));
      end
   endtask

   // empty list, fill, hit, eviction, no older stamp, stop point, saturation, wrap, boundary
   task automatic test_directed();
      int i;
      offer_request(REQ_LIST, 32'h0, 32'd50, 4'd10);
      offer_request(REQ_TRACK, 32'h0000_0000, 32'd1000, 4'd0);
      offer_request(REQ_TRACK, 32'hFFFF_FFFF, 32'd1100, 4'd15);
      offer_request(REQ_TRACK, 32'h0000_0000, 32'd1200, 4'd0);
      for (i = 2; i < TABLE_ENTRIES; i++)
         offer_request(REQ_TRACK, 32'hA5A5_0000 | i, 32'd1300 + 32'(i * 10), 4'd0);
      offer_request(REQ_LIST, 32'hFFFF_FFFF, 32'd1500, 4'd3);
      offer_request(REQ_TRACK, 32'h5A5A_5A5A, 32'd2000, 4'd0);
      offer_request(REQ_TRACK, 32'h1234_5678, 32'd0, 4'd0);
      offer_request(REQ_LIST, 32'h0, 32'd2100, 4'd15);
      offer_request(REQ_LIST, 32'h0, 32'hFFFF_0000, 4'd0);
      offer_request(REQ_LIST, 32'h0, 32'd40000, 4'd4);
      offer_request(REQ_TRACK, 32'hC0A8_0101, 32'hFFFF_FFF0, 4'd0);
      offer_request(REQ_LIST, 32'h0, 32'h0000_0010, 4'd10);
      offer_request(REQ_LIST, 32'h0, 32'h0000_0010, 4'd8);
      offer_request(REQ_TRACK, 32'h0A00_0001, 32'd100000, 4'd0);
      offer_request(REQ_LIST, 32'h0, 32'd130000, 4'd11);
      offer_request(REQ_LIST, 32'h0, 32'd130001, 4'd12);
      quiesce();
   endtask

   task automatic test_timeout_settings();
      int t;
      set_timeout(32'd0);
      random_traffic(16, 2);
      quiesce();
      set_timeout(32'hFFFF_FFFF);
      random_traffic(16, 32'h3FFF_FFFF);
      quiesce();
      t = $urandom_range(2000, 60000);
      set_timeout(TIME_W'(t));
      random_traffic(16, t / 3);
      quiesce();
      set_timeout(32'd1);
      random_traffic(16, 3);
      quiesce();
      set_timeout(TIMEOUT_RESET);
      random_traffic(16, 9000);
      quiesce();
   endtask

   task automatic test_steady_stream();
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      random_traffic(16, 6000);
      quiesce();
      req_idle_pct  = 30;
      rsp_stall_pct = 30;
   endtask

   task automatic test_backpressure();
      req_idle_pct = 0;
      rsp_hold_req = 300;
      random_traffic(12, 5000);
      quiesce();
      req_idle_pct = 30;
   endtask

   always @(posedge clock) begin
      if (rsp_hold_req != 0) begin
         rsp_hold_left = rsp_hold_req;
         rsp_hold_req  = 0;
      end
      if (rsp_hold_left != 0) begin
         rsp_hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   task automatic report_mismatch(input string what, input table_rsp_type want,
                                  input table_rsp_type got);
      if (mismatch_count < 10) begin
         $display("%0t %s: exp kind=%0d ip=%h slot=%0d hit=%b ev=%b cnt=%0d last=%b",
                  $time, what, want.kind, want.ip, want.slot, want.hit, want.evicted,
                  want.count, want.last);
         $display("   got kind=%0d ip=%h slot=%0d hit=%b ev=%b cnt=%0d last=%b",
                  got.kind, got.ip, got.slot, got.hit, got.evicted, got.count, got.last);
      end
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      table_rsp_type got;
      table_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got.kind    = rsp_item_kind;
         got.ip      = rsp_out_ip;
         got.slot    = rsp_slot_index;
         got.hit     = rsp_was_hit;
         got.evicted = rsp_evicted;
         got.count   = rsp_live_count;
         got.last    = rsp_last;
         if (awaited_rsp_q.size() == 0) begin
            report_mismatch("unexpected item", '0, got);
         end else begin
            want = awaited_rsp_q.pop_front();
            if (got.kind !== want.kind || got.ip !== want.ip || got.slot !== want.slot ||
                got.hit !== want.hit || got.evicted !== want.evicted ||
                got.count !== want.count || got.last !== want.last)
               report_mismatch("mismatch", want, got);
         end
      end
   end

   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_type       <= REQ_TRACK;
      req_ip_addr    <= '0;
      req_now_ms     <= '0;
      req_max_count  <= '0;
      csr_valid      <= 1'b0;
      csr_timeout_ms <= TIMEOUT_RESET;
      sh_timeout = TIMEOUT_RESET;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         sh_addr[i]  = '0;
         sh_stamp[i] = '0;
         sh_valid[i] = 1'b0;
      end
      for (int i = 0; i < POOL_SIZE; i++) addr_pool[i] = $urandom;
      wall_ms = $urandom;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_timeout_settings();
      test_steady_stream();
      test_backpressure();
      repeat (END_SETTLE) @(posedge clock);
      if (awaited_rsp_q.size() != 0)
         $display("%0d expected items never arrived", awaited_rsp_q.size());
      if (mismatch_count == 0 && awaited_rsp_q.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
